// File: rtl/core/mbsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_pkg: shared types and constants of the MIDI byte stream parser
// Event codes, MIDI byte codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	localparam int unsigned SYSEX_DEPTH_DEF = 64;
	localparam int unsigned LEN_W           = 7;

	// event kinds on the result channel
	typedef enum logic [2:0] {
		EV_NOTE_ON    = 3'd0,
		EV_NOTE_OFF   = 3'd1,
		EV_CTRL_CHG   = 3'd2,
		EV_PROG_CHG   = 3'd3,
		EV_PITCH_BEND = 3'd4,
		EV_SYSEX_BYTE = 3'd5,
		EV_GM_RESET   = 3'd6
	} event_kind_t;

	// MIDI byte codes
	localparam logic [7:0] B_SYSEX_START = 8'hF0;
	localparam logic [7:0] B_SYSEX_END   = 8'hF7;
	localparam logic [7:0] B_REALTIME    = 8'hF8;
	localparam logic [7:0] B_ACT_SENSE   = 8'hFE;

	// status nibbles
	localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
	localparam logic [3:0] NIB_CTRL_CHG  = 4'hB;
	localparam logic [3:0] NIB_PROG_CHG  = 4'hC;
	localparam logic [3:0] NIB_CH_PRESS  = 4'hD;
	localparam logic [3:0] NIB_BEND      = 4'hE;

	// GM System On body: 7E 7F 09 01
	localparam logic [7:0] GM_ON [4] = '{8'h7E, 8'h7F, 8'h09, 8'h01};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_EMIT
	} mbsp_state_t;

	typedef struct packed {
		logic load_byte;
		logic exec;
		logic rd_en;
		logic emit_sysex;
	} mbsp_cmd_t;

	typedef struct packed {
		logic single;
		logic walk;
		logic last;
		logic slot_free;
	} mbsp_status_t;

	typedef struct packed {
		event_kind_t       event_kind;
		logic [3:0]        channel;
		logic [6:0]        key_or_controller;
		logic [6:0]        velocity_or_value;
		logic [13:0]       bend_amount;
		logic [7:0]        sysex_data;
		logic [LEN_W-1:0]  sysex_length;
		logic              last_of_run;
	} mbsp_event_t;

endpackage

// File: rtl/core/mbsp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_byte_if: received byte channel
// Valid/ready channel carrying one MIDI byte per request.
// ----------------------------------------------------------------------------
interface mbsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/mbsp_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_event_if: parsed event channel
// Valid/ready channel carrying one parsed MIDI event per request.
// ----------------------------------------------------------------------------
interface mbsp_event_if import mbsp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       event_kind;
	logic [3:0]       channel;
	logic [6:0]       key_or_controller;
	logic [6:0]       velocity_or_value;
	logic [13:0]      bend_amount;
	logic [7:0]       sysex_data;
	logic [LEN_W-1:0] sysex_length;
	logic             last_of_run;

	modport source(output valid, output event_kind, output channel,
		output key_or_controller, output velocity_or_value, output bend_amount,
		output sysex_data, output sysex_length, output last_of_run, input ready);
	modport sink(input valid, input event_kind, input channel,
		input key_or_controller, input velocity_or_value, input bend_amount,
		input sysex_data, input sysex_length, input last_of_run, output ready);
endinterface

// File: rtl/core/mbsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_ctrl: parser sequencer
// Takes one byte, executes it, and walks the sysex store on a flush.
// ----------------------------------------------------------------------------
module mbsp_ctrl import mbsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mbsp_status_t st,
	output mbsp_cmd_t    cmd
);

	mbsp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_byte = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (st.walk) begin
					cmd.exec = 1'b1;
					state_d  = ST_READ;
				end else if (!st.single || st.slot_free) begin
					// hold a single event until the output slot frees up
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.slot_free) begin
					cmd.emit_sysex = 1'b1;
					state_d        = st.last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/mbsp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_datapath: parser state, sysex store and output register
// Decodes the held byte against running status and sysex state.
// ----------------------------------------------------------------------------
module mbsp_datapath import mbsp_pkg::*; #(
	parameter int unsigned SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   in_byte,
	input  mbsp_cmd_t    cmd,
	output mbsp_status_t st,
	input  logic         out_ready,
	output logic         out_valid,
	output mbsp_event_t  out_event
);

	localparam int unsigned CW = $clog2(SYSEX_DEPTH + 1);
	localparam int unsigned IW = $clog2(SYSEX_DEPTH);

	logic [7:0]    byte_q;
	logic          in_sysex_q;
	logic [CW-1:0] count_q;
	logic [3:0]    nibble_q;
	logic [3:0]    chan_q;
	logic          await_q;
	logic [6:0]    held_q;
	logic [CW-1:0] len_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    rd_q;
	logic [7:0]    gm_q [4];
	logic [7:0]    mem [SYSEX_DEPTH];
	logic          out_valid_q;
	mbsp_event_t   out_q;

	logic          is_end;
	logic          gm_hit;
	logic          chev;
	logic [CW-1:0] count_adj;
	logic          store_wr;
	logic [6:0]    second, third;
	mbsp_event_t   single_ev;
	mbsp_event_t   sysex_ev;
	logic          load_single;

	always_comb begin
		is_end    = in_sysex_q && (byte_q == B_SYSEX_END);
		count_adj = (count_q == CW'(SYSEX_DEPTH)) ? '0 : count_q;
		store_wr  = in_sysex_q && (byte_q != B_SYSEX_END) && (byte_q != B_ACT_SENSE);
		gm_hit    = (count_q == CW'(4)) && (gm_q[0] == GM_ON[0]) && (gm_q[1] == GM_ON[1])
			&& (gm_q[2] == GM_ON[2]) && (gm_q[3] == GM_ON[3]);
		chev      = !in_sysex_q && !byte_q[7]
			&& (await_q || nibble_q == NIB_PROG_CHG || nibble_q == NIB_CH_PRESS)
			&& (nibble_q inside {NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CTRL_CHG, NIB_PROG_CHG,
				NIB_BEND});
		second    = await_q ? held_q : byte_q[6:0];
		third     = await_q ? byte_q[6:0] : 7'd0;

		single_ev             = '0;
		single_ev.last_of_run = 1'b1;
		if (in_sysex_q) begin
			single_ev.event_kind = gm_hit ? EV_GM_RESET : EV_SYSEX_BYTE;
		end else begin
			single_ev.channel = chan_q;
			case (nibble_q)
				NIB_NOTE_ON: begin
					single_ev.key_or_controller = second;
					if (third != 7'd0) begin
						single_ev.event_kind        = EV_NOTE_ON;
						single_ev.velocity_or_value = third;
					end else begin
						single_ev.event_kind = EV_NOTE_OFF;
					end
				end
				NIB_NOTE_OFF: begin
					single_ev.event_kind        = EV_NOTE_OFF;
					single_ev.key_or_controller = second;
				end
				NIB_CTRL_CHG: begin
					single_ev.event_kind        = EV_CTRL_CHG;
					single_ev.key_or_controller = second;
					single_ev.velocity_or_value = third;
				end
				NIB_PROG_CHG: begin
					single_ev.event_kind        = EV_PROG_CHG;
					single_ev.key_or_controller = second;
				end
				NIB_BEND: begin
					single_ev.event_kind  = EV_PITCH_BEND;
					single_ev.bend_amount = {third, second};
				end
				default: begin
					single_ev.event_kind = EV_NOTE_ON;
				end
			endcase
		end

		sysex_ev              = '0;
		sysex_ev.event_kind   = EV_SYSEX_BYTE;
		sysex_ev.sysex_data   = rd_q;
		sysex_ev.sysex_length = LEN_W'(len_q);
		sysex_ev.last_of_run  = st.last;
	end

	assign st.walk      = is_end && !gm_hit && (count_q != '0);
	assign st.single    = (is_end && !st.walk) || chev;
	assign st.last      = ((CW'(idx_q) + CW'(1)) == len_q);
	assign st.slot_free = !out_valid_q || out_ready;
	assign load_single  = cmd.exec && st.single;

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= in_byte;
		end
		if (cmd.exec && store_wr) begin
			mem[count_adj[IW-1:0]] <= byte_q;
			if (count_adj < CW'(4)) begin
				gm_q[count_adj[1:0]] <= byte_q;
			end
		end
		if (cmd.rd_en) begin
			rd_q <= mem[idx_q];
		end
		if (load_single) begin
			out_q <= single_ev;
		end else if (cmd.emit_sysex) begin
			out_q <= sysex_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sysex_q  <= 1'b0;
			count_q     <= '0;
			nibble_q    <= '0;
			chan_q      <= '0;
			await_q     <= 1'b0;
			held_q      <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (in_sysex_q) begin
					if (is_end) begin
						in_sysex_q <= 1'b0;
						count_q    <= '0;
						len_q      <= count_q;
						idx_q      <= '0;
					end else if (store_wr) begin
						count_q <= count_adj + CW'(1);
					end else begin
						count_q <= count_adj;
					end
				end else if (byte_q == B_SYSEX_START) begin
					count_q    <= '0;
					in_sysex_q <= 1'b1;
				end else if (byte_q[7]) begin
					if (byte_q < B_REALTIME) begin
						nibble_q <= byte_q[7:4];
						chan_q   <= byte_q[3:0];
						await_q  <= 1'b0;
					end
				end else if (await_q) begin
					await_q <= 1'b0;
				end else if (nibble_q < NIB_PROG_CHG || nibble_q == NIB_BEND) begin
					await_q <= 1'b1;
					held_q  <= byte_q[6:0];
				end else if (nibble_q < NIB_BEND) begin
					held_q <= byte_q[6:0];
				end
			end
			if (cmd.emit_sysex) begin
				idx_q <= idx_q + IW'(1);
			end
			if (load_single || cmd.emit_sysex) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_event = out_q;

endmodule

// File: rtl/core/midi_byte_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser: MIDI running status and system exclusive parser
// Turns received MIDI bytes into channel events, sysex byte runs and GM resets.
// ----------------------------------------------------------------------------
// Each received byte is taken in the idle state and applied in the execute
// state to the running status (or the sysex store), which also loads the
// result into the output register when the byte completes a message. An
// output register sits in front of the event channel, so a result may wait
// there while the next byte is taken; a byte that makes a new result waits in
// the execute state until that register is free. A 0xF7 ending a system
// exclusive message with N stored bytes (N nonzero, and not the four-byte GM
// System On body) walks the single-port sysex store, emitting each byte once
// the output register is free, and takes no new byte until the last result
// of the run is in the output register. Real-time bytes outside sysex are
// dropped, 0xFE is dropped inside sysex, and the store index wraps to zero
// once SYSEX_DEPTH bytes are held. The sysex store has no reset; nothing
// reads an entry before it is written. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser import mbsp_pkg::*; #(
	parameter int unsigned SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mbsp_byte_if.sink    rx,
	mbsp_event_if.source evt
);

	mbsp_cmd_t    cmd;
	mbsp_status_t st;
	mbsp_event_t  ev;

	// sequencer: take, execute, walk the store
	mbsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// running status, sysex store and output register
	mbsp_datapath #(
		.SYSEX_DEPTH (SYSEX_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (rx.rx_byte),
		.cmd       (cmd),
		.st        (st),
		.out_ready (evt.ready),
		.out_valid (evt.valid),
		.out_event (ev)
	);

	// drive the event channel fields from the output register
	assign evt.event_kind        = ev.event_kind;
	assign evt.channel           = ev.channel;
	assign evt.key_or_controller = ev.key_or_controller;
	assign evt.velocity_or_value = ev.velocity_or_value;
	assign evt.bend_amount       = ev.bend_amount;
	assign evt.sysex_data        = ev.sysex_data;
	assign evt.sysex_length      = ev.sysex_length;
	assign evt.last_of_run       = ev.last_of_run;

	// never load a result over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.exec && st.single) || cmd.emit_sysex) |-> st.slot_free)
		else $error("result loaded over a waiting result");

	// one byte at a time: the cycle after a request the port is closed
	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |=> !rx.ready)
		else $error("byte taken while the previous one is in work");

	// the last byte of a flush run returns to taking requests
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sysex && st.last) |=> rx.ready)
		else $error("flush did not finish after the last byte");

	// a flush walk never starts while a single event is also decoded
	a_walk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		st.walk |-> !st.single)
		else $error("flush walk and single event decoded together");

endmodule
